@@ rtl/arpc_pkg.sv @@
// shared types, request codes and defaults for the arp cache lru table
`default_nettype none

package arpc_pkg;

   // default number of table slots
   localparam int ENTRIES_DEFAULT = 16;

   // field widths
   localparam int REQ_W   = 2;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int INDEX_W = 8;
   localparam int STAMP_W = 64;

   // request codes
   localparam logic [REQ_W-1:0] REQ_INSERT   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SNAPSHOT = 2'd2;
   localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd3;

   // one stored slot word
   typedef struct packed {
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // flags gathered by the scan unit
   typedef struct packed {
      logic match_found;
      logic free_found;
   } scan_status_type;

endpackage

`default_nettype wire

@@ rtl/arpc_table.sv @@
// slot memory with one write port, one registered read port and per-slot valid bits
`default_nettype none

module arpc_table #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT,
   parameter int IW      = $clog2(ENTRIES)
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 clear_all,
   input  wire                 wr_en,
   input  wire  [IW-1:0]       wr_addr,
   input  arpc_pkg::entry_type wr_data,
   input  wire                 rd_en,
   input  wire  [IW-1:0]       rd_addr,
   output arpc_pkg::entry_type rd_data,
   output logic                rd_valid
);

   arpc_pkg::entry_type mem [ENTRIES];
   arpc_pkg::entry_type rd_data_ff;
   logic [ENTRIES-1:0]  valid_ff;
   logic                rd_valid_ff;

   // slot storage, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // valid bits, cleared at once on reset or table clear
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an empty slot reads as all zero
   assign rd_data  = rd_valid_ff ? rd_data_ff : '0;
   assign rd_valid = rd_valid_ff;

endmodule

`default_nettype wire

@@ rtl/arpc_scan.sv @@
// shared compare unit: first match, first free slot and oldest stamp over scanned beats
`default_nettype none

module arpc_scan #(
   parameter int IW = 4
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        clear,
   input  wire                        beat_en,
   input  wire  [IW-1:0]              beat_idx,
   input  wire                        beat_valid,
   input  arpc_pkg::entry_type        beat_data,
   input  wire  [arpc_pkg::IP_W-1:0]  key_ip,
   output arpc_pkg::scan_status_type  status,
   output logic [IW-1:0]              match_idx,
   output logic [arpc_pkg::MAC_W-1:0] match_mac,
   output logic [IW-1:0]              free_idx,
   output logic [IW-1:0]              lru_idx,
   output logic [arpc_pkg::IP_W-1:0]  lru_ip
);

   logic                          match_found_ff;
   logic                          free_found_ff;
   logic                          lru_seen_ff;
   logic [IW-1:0]                 match_idx_ff;
   logic [arpc_pkg::MAC_W-1:0]    match_mac_ff;
   logic [IW-1:0]                 free_idx_ff;
   logic [IW-1:0]                 lru_idx_ff;
   logic [arpc_pkg::IP_W-1:0]     lru_ip_ff;
   logic [arpc_pkg::STAMP_W-1:0]  best_stamp_ff;
   logic                          hit;
   logic                          older;

   // key compare and stamp compare for the current beat
   assign hit   = beat_valid && (beat_data.ip == key_ip);
   assign older = !lru_seen_ff || (beat_data.stamp < best_stamp_ff);

   // found flags
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         lru_seen_ff    <= 1'b0;
      end else if (beat_en) begin
         if (hit) begin
            match_found_ff <= 1'b1;
         end
         if (!beat_valid) begin
            free_found_ff <= 1'b1;
         end
         if (beat_valid && older) begin
            lru_seen_ff <= 1'b1;
         end
      end
   end

   // captured slot data, earliest slot kept on ties
   always_ff @(posedge clock) begin
      if (beat_en) begin
         if (hit && !match_found_ff) begin
            match_idx_ff <= beat_idx;
            match_mac_ff <= beat_data.mac;
         end
         if (!beat_valid && !free_found_ff) begin
            free_idx_ff <= beat_idx;
         end
         if (beat_valid && older) begin
            lru_idx_ff    <= beat_idx;
            lru_ip_ff     <= beat_data.ip;
            best_stamp_ff <= beat_data.stamp;
         end
      end
   end

   assign status.match_found = match_found_ff;
   assign status.free_found  = free_found_ff;
   assign match_idx          = match_idx_ff;
   assign match_mac          = match_mac_ff;
   assign free_idx           = free_idx_ff;
   assign lru_idx            = lru_idx_ff;
   assign lru_ip             = lru_ip_ff;

endmodule

`default_nettype wire

@@ rtl/arp_cache_lru_table_top.sv @@
// top level: request sequencer, use clock and result registers of the arp cache lru table
`default_nettype none

// Fully associative IPv4-to-MAC table of ENTRIES slots with least-recently-used
// replacement. A request is taken when start is high and busy is low; busy then
// stays high until the result is out. Insert and lookup read every slot once
// through the single memory read port, then finish the compare and commit the
// result; snapshot reads the slot at the request index when it is in range, and
// clear empties the table. Every request gives exactly one result beat on the
// rsp_ ports, marked by rsp_strobe for one cycle; the receiver cannot stall, so
// it must take each beat as it comes. A new request may be started in the same
// cycle as the previous result beat.
module arp_cache_lru_table_top #(
   parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   output logic                            busy,
   input  wire  [arpc_pkg::REQ_W-1:0]      req_type,
   input  wire  [arpc_pkg::IP_W-1:0]       req_ip_addr,
   input  wire  [arpc_pkg::MAC_W-1:0]      req_mac_addr,
   input  wire  [arpc_pkg::INDEX_W-1:0]    req_entry_index,
   output logic                            rsp_strobe,
   output logic                            rsp_ok,
   output logic [arpc_pkg::MAC_W-1:0]      rsp_mac_result,
   output logic                            rsp_entry_valid,
   output logic [arpc_pkg::IP_W-1:0]       rsp_entry_ip,
   output logic [arpc_pkg::STAMP_W-1:0]    rsp_entry_stamp,
   output logic                            rsp_evicted,
   output logic [arpc_pkg::IP_W-1:0]       rsp_victim_ip
);

   localparam int IW = $clog2(ENTRIES);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_LAST     = 3'd2;
   localparam logic [2:0] ST_COMMIT   = 3'd3;
   localparam logic [2:0] ST_SNAP_RD  = 3'd4;
   localparam logic [2:0] ST_SNAP_RSP = 3'd5;
   localparam logic [2:0] ST_CLEAR    = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [IW-1:0]                    cnt_ff, cnt_in;
   logic [arpc_pkg::STAMP_W-1:0]     clk_ff, clk_in;
   logic                             beat_en_ff;
   logic [IW-1:0]                    beat_idx_ff;

   logic [arpc_pkg::REQ_W-1:0]       req_type_ff;
   logic [arpc_pkg::IP_W-1:0]        req_ip_ff;
   logic [arpc_pkg::MAC_W-1:0]       req_mac_ff;
   logic [arpc_pkg::INDEX_W-1:0]     req_idx_ff;

   logic                             strobe_ff, strobe_in;
   logic                             ok_ff, ok_in;
   logic [arpc_pkg::MAC_W-1:0]       mac_ff, mac_in;
   logic                             ev_ff, ev_in;
   logic [arpc_pkg::IP_W-1:0]        ev_ip_ff, ev_ip_in;
   logic                             ent_valid_ff, ent_valid_in;
   logic [arpc_pkg::IP_W-1:0]        ent_ip_ff, ent_ip_in;
   logic [arpc_pkg::STAMP_W-1:0]     ent_stamp_ff, ent_stamp_in;

   logic                             accept;
   logic                             in_range;
   logic [arpc_pkg::STAMP_W-1:0]     stamp_next;
   logic [IW-1:0]                    victim;

   logic                             clear_all;
   logic                             wr_en;
   logic [IW-1:0]                    wr_addr;
   arpc_pkg::entry_type              wr_data;
   logic                             rd_en;
   logic [IW-1:0]                    rd_addr;
   arpc_pkg::entry_type              rd_data;
   logic                             rd_valid;

   arpc_pkg::scan_status_type        scan_status;
   logic [IW-1:0]                    match_idx;
   logic [arpc_pkg::MAC_W-1:0]       match_mac;
   logic [IW-1:0]                    free_idx;
   logic [IW-1:0]                    lru_idx;
   logic [arpc_pkg::IP_W-1:0]        lru_ip;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && (state_ff == ST_IDLE);
   assign in_range   = req_idx_ff < arpc_pkg::INDEX_W'(ENTRIES);
   assign stamp_next = clk_ff + arpc_pkg::STAMP_W'(1);

   // slot chosen by an insert: match, else first free, else oldest
   assign victim = scan_status.match_found ? match_idx :
                   scan_status.free_found  ? free_idx  : lru_idx;

   // slot storage
   arpc_table #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .clear_all (clear_all),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .rd_valid  (rd_valid)
   );

   // compare unit fed one slot per cycle
   arpc_scan #(
      .IW (IW)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .beat_en    (beat_en_ff),
      .beat_idx   (beat_idx_ff),
      .beat_valid (rd_valid),
      .beat_data  (rd_data),
      .key_ip     (req_ip_ff),
      .status     (scan_status),
      .match_idx  (match_idx),
      .match_mac  (match_mac),
      .free_idx   (free_idx),
      .lru_idx    (lru_idx),
      .lru_ip     (lru_ip)
   );

   // sequencer and result selection
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clk_in       = clk_ff;
      clear_all    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = victim;
      wr_data.ip   = req_ip_ff;
      wr_data.mac  = req_mac_ff;
      wr_data.stamp = stamp_next;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;
      strobe_in    = 1'b0;
      ok_in        = 1'b0;
      mac_in       = '0;
      ev_in        = 1'b0;
      ev_ip_in     = '0;
      ent_valid_in = 1'b0;
      ent_ip_in    = '0;
      ent_stamp_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cnt_in = '0;
               case (req_type)
                  arpc_pkg::REQ_INSERT:   state_in = ST_SCAN;
                  arpc_pkg::REQ_LOOKUP:   state_in = ST_SCAN;
                  arpc_pkg::REQ_SNAPSHOT: state_in = ST_SNAP_RD;
                  default:                state_in = ST_CLEAR;
               endcase
            end
         end
         ST_SCAN: begin
            rd_en = 1'b1;
            if (cnt_ff == IW'(ENTRIES - 1)) begin
               state_in = ST_LAST;
            end else begin
               cnt_in = cnt_ff + IW'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            if (req_type_ff == arpc_pkg::REQ_INSERT) begin
               wr_en  = 1'b1;
               clk_in = stamp_next;
               ok_in  = 1'b1;
               if (!scan_status.match_found && !scan_status.free_found) begin
                  ev_in    = 1'b1;
                  ev_ip_in = lru_ip;
               end
            end else if (scan_status.match_found) begin
               // lookup hit refreshes the stamp
               wr_en       = 1'b1;
               wr_addr     = match_idx;
               wr_data.mac = match_mac;
               clk_in      = stamp_next;
               ok_in       = 1'b1;
               mac_in      = match_mac;
            end
         end
         ST_SNAP_RD: begin
            rd_en    = in_range;
            rd_addr  = req_idx_ff[IW-1:0];
            state_in = ST_SNAP_RSP;
         end
         ST_SNAP_RSP: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            if (in_range) begin
               ok_in        = 1'b1;
               mac_in       = rd_data.mac;
               ent_valid_in = rd_valid;
               ent_ip_in    = rd_data.ip;
               ent_stamp_in = rd_data.stamp;
            end
         end
         ST_CLEAR: begin
            clear_all = 1'b1;
            clk_in    = '0;
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            ok_in     = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         clk_ff     <= '0;
         beat_en_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         clk_ff     <= clk_in;
         beat_en_ff <= (state_ff == ST_SCAN);
         strobe_ff  <= strobe_in;
      end
   end

   // request beat capture and scan index tag
   always_ff @(posedge clock) begin
      beat_idx_ff <= cnt_ff;
      if (accept) begin
         req_type_ff <= req_type;
         req_ip_ff   <= req_ip_addr;
         req_mac_ff  <= req_mac_addr;
         req_idx_ff  <= req_entry_index;
      end
   end

   // result beat registers
   always_ff @(posedge clock) begin
      if (strobe_in) begin
         ok_ff        <= ok_in;
         mac_ff       <= mac_in;
         ev_ff        <= ev_in;
         ev_ip_ff     <= ev_ip_in;
         ent_valid_ff <= ent_valid_in;
         ent_ip_ff    <= ent_ip_in;
         ent_stamp_ff <= ent_stamp_in;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_mac_result  = mac_ff;
   assign rsp_entry_valid = ent_valid_ff;
   assign rsp_entry_ip    = ent_ip_ff;
   assign rsp_entry_stamp = ent_stamp_ff;
   assign rsp_evicted     = ev_ff;
   assign rsp_victim_ip   = ev_ip_ff;

endmodule

`default_nettype wire
